/* hw/rtl/cle_pkg.sv */
// Shared constants and types for the cooked line editor.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int LINE_DEPTH = 256;
  localparam int AW         = $clog2(LINE_DEPTH);

  // result kinds
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2,
    KIND_BUSY = 2'd3
  } kind_t;

  // request selector
  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int TAB_WIDTH = 4;

endpackage

`default_nettype wire

/* hw/rtl/cle_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cooked_line_editor.sv */
// Top level of the cooked line editor: request decode, line state and result sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Terminal line discipline.
// Input stream: in_tuser selects feed (0) or read (1), in_tdata carries the character.
// Output stream: out_tuser is the result kind, out_tdata the byte, out_tlast marks the
// final result of a request. Requests that produce no result (backspace on an empty
// line, a character into a full line) emit nothing.
// cfg_wr_en/cfg_wr_data write the cooked_mode bit; write only while idle.
// A request's first result passes the sequencer register and then the output register
// before it shows on out_tvalid. A shared sequencer gives one result per cycle while
// the receiver does not stall; backspace gives three results and tab up to 4 spaces
// (one space and one line-store write per cycle, unless stalled). The next request is
// taken in the cycle its predecessor's last result moves into the output register, so
// single-result requests run back to back. Line store reads (one per read request) come
// from the registered RAM read; a read that meets the line's final write is forwarded.
// Reset clears line length, read position, complete flag and sets cooked mode; the
// line store is not cleared and needs no clearing pass.
// When the receiver stalls the output register holds, the sequencer waits, and
// in_tready drops once a request is pending in the sequencer.
module cooked_line_editor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_byte
  input  wire logic       in_tuser,   // [0] func
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [7:0] out_byte
  output logic      [1:0] out_tuser,  // [1:0] kind
  output logic            out_tlast,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);

  localparam int AW = cle_pkg::AW;
  localparam logic [AW-1:0] STORE_LIMIT = AW'(cle_pkg::LINE_DEPTH - 2);

  // line state
  logic          cooked_r;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic          complete_r, complete_nxt;

  // result sequencer
  logic          gen_valid_r, gen_valid_nxt;
  logic [2:0]    gen_cnt_r, gen_cnt_nxt;
  cle_pkg::kind_t gen_kind_r, gen_kind_nxt;
  logic [7:0]    gen_byte_r, gen_byte_nxt;
  logic          gen_bs_r, gen_bs_nxt;
  logic          gen_store_r, gen_store_nxt;
  logic          gen_ram_r, gen_ram_nxt;
  logic [AW-1:0] gen_addr_r, gen_addr_nxt;

  // output register
  logic          out_valid_r;
  cle_pkg::kind_t out_kind_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          fwd_r;
  logic [7:0]    fwd_data_r;

  logic          emit, accept;
  logic [7:0]    beat_byte;
  logic          ram_we, ram_re;
  logic [7:0]    ram_rd_data;
  logic [AW-1:0] room;
  logic [2:0]    tab_n;

  assign emit      = gen_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !gen_valid_r || (emit && gen_cnt_r == 3'd1);
  assign accept    = in_tvalid && in_tready;

  // middle beat of the backspace sequence is a space
  always_comb begin
    if (gen_ram_r) begin
      beat_byte = fwd_r ? fwd_data_r : ram_rd_data;
    end else if (gen_bs_r) begin
      beat_byte = (gen_cnt_r == 3'd2) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
    end else begin
      beat_byte = gen_byte_r;
    end
  end

  assign ram_we = emit && gen_store_r;
  assign ram_re = accept && (in_tuser == cle_pkg::FUNC_READ) && cooked_r && complete_r &&
                  (pos_r < len_r);

  assign room  = STORE_LIMIT - len_r;
  assign tab_n = (room >= AW'(cle_pkg::TAB_WIDTH)) ? 3'(cle_pkg::TAB_WIDTH) : room[2:0];

  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    complete_nxt  = complete_r;
    gen_valid_nxt = gen_valid_r;
    gen_cnt_nxt   = gen_cnt_r;
    gen_kind_nxt  = gen_kind_r;
    gen_byte_nxt  = gen_byte_r;
    gen_bs_nxt    = gen_bs_r;
    gen_store_nxt = gen_store_r;
    gen_ram_nxt   = gen_ram_r;
    gen_addr_nxt  = gen_addr_r;

    if (emit) begin
      gen_cnt_nxt  = gen_cnt_r - 3'd1;
      gen_addr_nxt = gen_addr_r + AW'(1);
      if (gen_cnt_r == 3'd1) begin
        gen_valid_nxt = 1'b0;
      end
    end

    if (accept) begin
      gen_valid_nxt = 1'b1;
      gen_cnt_nxt   = 3'd1;
      gen_kind_nxt  = cle_pkg::KIND_ECHO;
      gen_byte_nxt  = 8'd0;
      gen_bs_nxt    = 1'b0;
      gen_store_nxt = 1'b0;
      gen_ram_nxt   = 1'b0;
      gen_addr_nxt  = len_r;

      if (in_tuser == cle_pkg::FUNC_READ) begin
        if (ram_re) begin
          gen_kind_nxt = cle_pkg::KIND_DATA;
          gen_ram_nxt  = 1'b1;
          pos_nxt      = pos_r + AW'(1);
          if (pos_r + AW'(1) >= len_r) begin
            complete_nxt = 1'b0;
            len_nxt      = '0;
            pos_nxt      = '0;
          end
        end else begin
          gen_kind_nxt = cle_pkg::KIND_NONE;
        end
      end else if (!cooked_r) begin
        gen_kind_nxt = cle_pkg::KIND_DATA;
        gen_byte_nxt = in_tdata;
      end else if (complete_r) begin
        gen_kind_nxt = cle_pkg::KIND_BUSY;
      end else begin
        case (in_tdata)
          cle_pkg::CH_BS, cle_pkg::CH_DEL: begin
            if (len_r != '0) begin
              len_nxt     = len_r - AW'(1);
              gen_cnt_nxt = 3'd3;
              gen_bs_nxt  = 1'b1;
            end else begin
              gen_valid_nxt = 1'b0;
            end
          end
          cle_pkg::CH_LF, cle_pkg::CH_CR: begin
            gen_byte_nxt  = cle_pkg::CH_LF;
            gen_store_nxt = 1'b1;
            len_nxt       = len_r + AW'(1);
            complete_nxt  = 1'b1;
            pos_nxt       = '0;
          end
          cle_pkg::CH_ESC: begin
            gen_byte_nxt = cle_pkg::CH_LF;
            len_nxt      = '0;
          end
          cle_pkg::CH_TAB: begin
            if (len_r < STORE_LIMIT) begin
              gen_cnt_nxt   = tab_n;
              gen_byte_nxt  = cle_pkg::CH_SPACE;
              gen_store_nxt = 1'b1;
              len_nxt       = len_r + AW'(tab_n);
            end else begin
              gen_valid_nxt = 1'b0;
            end
          end
          default: begin
            if (len_r < STORE_LIMIT) begin
              gen_byte_nxt  = in_tdata;
              gen_store_nxt = 1'b1;
              len_nxt       = len_r + AW'(1);
            end else begin
              gen_valid_nxt = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooked_r    <= 1'b1;
      len_r       <= '0;
      pos_r       <= '0;
      complete_r  <= 1'b0;
      gen_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cooked_r <= cfg_wr_data;
      end
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      complete_r  <= complete_nxt;
      gen_valid_r <= gen_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    gen_cnt_r   <= gen_cnt_nxt;
    gen_kind_r  <= gen_kind_nxt;
    gen_byte_r  <= gen_byte_nxt;
    gen_bs_r    <= gen_bs_nxt;
    gen_store_r <= gen_store_nxt;
    gen_ram_r   <= gen_ram_nxt;
    gen_addr_r  <= gen_addr_nxt;
    if (emit) begin
      out_kind_r <= gen_kind_r;
      out_byte_r <= beat_byte;
      out_last_r <= (gen_cnt_r == 3'd1);
    end
    // a read hitting the entry written this cycle takes the write data
    if (ram_re) begin
      fwd_r      <= ram_we && (gen_addr_r == pos_r);
      fwd_data_r <= beat_byte;
    end
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (cle_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (gen_addr_r),
    .wr_data (beat_byte),
    .rd_en   (ram_re),
    .rd_addr (pos_r),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
